// ===== hw/rtl/checksummed_frame_receiver_defines.svh =====
// Assertion macros shared by the checksummed frame receiver RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef CHECKSUMMED_FRAME_RECEIVER_DEFINES_SVH
`define CHECKSUMMED_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CFR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define CFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/cfr_pkg.sv =====
// Types and codes shared by the checksummed frame receiver modules.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package cfr_pkg;

   // Parser phase, one-hot.
   typedef enum logic [4:0] {
      PH_HUNT    = 5'b00001,
      PH_LEN_HI  = 5'b00010,
      PH_LEN_LO  = 5'b00100,
      PH_PAYLOAD = 5'b01000,
      PH_CHECK   = 5'b10000
   } phase_type;

   // Result kind codes as seen on the result channel.
   typedef enum logic [2:0] {
      K_DATA     = 3'd0,
      K_GOOD     = 3'd1,
      K_BAD_ID   = 3'd2,
      K_TOO_LONG = 3'd3,
      K_BAD_SUM  = 3'd4
   } kind_type;

   // Configuration register indexes.
   localparam logic CSR_FRAME_ID    = 1'b0;
   localparam logic CSR_MAX_PAYLOAD = 1'b1;

   localparam logic [7:0]  FRAME_ID_RESET    = 8'h00;
   localparam logic [15:0] MAX_PAYLOAD_RESET = 16'hFFFF;

   typedef struct packed {
      logic [7:0]  frame_id;
      logic [15:0] max_payload;
   } cfg_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data_byte;
      logic [15:0] frame_length;
   } item_type;

endpackage

`default_nettype wire

// ===== hw/rtl/cfr_parser.sv =====
// Frame parser: phase, length, countdown and running checksum registers.
// Depends on cfr_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "checksummed_frame_receiver_defines.svh"

module cfr_parser (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [7:0]        rx_byte,
   input  wire cfr_pkg::cfg_type  cfg,
   output logic                   res_valid,
   output cfr_pkg::item_type      res_item
);

   cfr_pkg::phase_type phase_ff, phase_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] left_ff, left_in;
   logic [7:0]  sum_ff, sum_in;
   logic [15:0] full_length;

   assign full_length = {length_ff[15:8], rx_byte};

   always_comb begin
      phase_in  = phase_ff;
      length_in = length_ff;
      left_in   = left_ff;
      sum_in    = sum_ff;
      res_valid = 1'b0;
      res_item.kind         = cfr_pkg::K_DATA;
      res_item.data_byte    = 8'h00;
      res_item.frame_length = 16'h0000;
      if (accept) begin
         unique case (phase_ff)
            cfr_pkg::PH_LEN_HI: begin
               length_in = {rx_byte, 8'h00};
               sum_in    = sum_ff + rx_byte;
               phase_in  = cfr_pkg::PH_LEN_LO;
            end
            cfr_pkg::PH_LEN_LO: begin
               length_in = full_length;
               sum_in    = sum_ff + rx_byte;
               if (full_length > cfg.max_payload) begin
                  phase_in              = cfr_pkg::PH_HUNT;
                  res_valid             = 1'b1;
                  res_item.kind         = cfr_pkg::K_TOO_LONG;
                  res_item.frame_length = full_length;
               end else begin
                  left_in  = full_length;
                  phase_in = (full_length == 16'h0000) ? cfr_pkg::PH_CHECK
                                                       : cfr_pkg::PH_PAYLOAD;
               end
            end
            cfr_pkg::PH_PAYLOAD: begin
               sum_in  = sum_ff + rx_byte;
               left_in = left_ff - 16'd1;
               if (left_ff == 16'd1) begin
                  phase_in = cfr_pkg::PH_CHECK;
               end
               res_valid          = 1'b1;
               res_item.kind      = cfr_pkg::K_DATA;
               res_item.data_byte = rx_byte;
            end
            cfr_pkg::PH_CHECK: begin
               phase_in              = cfr_pkg::PH_HUNT;
               res_valid             = 1'b1;
               res_item.kind         = (rx_byte == sum_ff) ? cfr_pkg::K_GOOD
                                                           : cfr_pkg::K_BAD_SUM;
               res_item.frame_length = length_ff;
            end
            default: begin
               if (rx_byte == cfg.frame_id) begin
                  sum_in    = rx_byte;
                  length_in = 16'h0000;
                  left_in   = 16'h0000;
                  phase_in  = cfr_pkg::PH_LEN_HI;
               end else begin
                  phase_in      = cfr_pkg::PH_HUNT;
                  res_valid     = 1'b1;
                  res_item.kind = cfr_pkg::K_BAD_ID;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= cfr_pkg::PH_HUNT;
         length_ff <= 16'h0000;
         left_ff   <= 16'h0000;
         sum_ff    <= 8'h00;
      end else begin
         phase_ff  <= phase_in;
         length_ff <= length_in;
         left_ff   <= left_in;
         sum_ff    <= sum_in;
      end
   end

   // A payload phase always has at least one byte still to come.
   `CFR_ASSERT_IMP(a_payload_left, clock, reset, phase_ff == cfr_pkg::PH_PAYLOAD,
      left_ff != 16'h0000, "payload phase with no bytes left")
   // Only payload results carry a data byte.
   `CFR_ASSERT_IMP(a_data_zero, clock, reset,
      res_valid && (res_item.kind != cfr_pkg::K_DATA),
      res_item.data_byte == 8'h00, "non-payload result with data byte")
   // Results are only produced for accepted items.
   `CFR_ASSERT_IMP(a_res_accept, clock, reset, res_valid, accept,
      "result without an accepted item")

endmodule

`default_nettype wire

// ===== hw/rtl/cfr_out_buf.sv =====
// Result register with a one-entry skid stage behind it.
// Depends on cfr_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "checksummed_frame_receiver_defines.svh"

module cfr_out_buf (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push_valid,
   input  wire cfr_pkg::item_type  push_item,
   input  wire logic               rsp_stall,
   output logic                    rsp_valid,
   output cfr_pkg::item_type       rsp_item,
   output logic                    full
);

   logic out_valid_ff, out_valid_in;
   logic skid_valid_ff, skid_valid_in;
   cfr_pkg::item_type out_ff, out_in;
   cfr_pkg::item_type skid_ff, skid_in;
   logic pop;

   assign pop = out_valid_ff && !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push_valid) begin
         if (!out_valid_ff || pop) begin
            out_in       = push_item;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = push_item;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_ff;
   assign full      = skid_valid_ff;

   // The skid stage only fills behind a waiting result.
   `CFR_ASSERT_IMP(a_skid_behind, clock, reset, skid_valid_ff, out_valid_ff,
      "skid stage holds an item while the result register is empty")
   // Nothing is pushed while the skid stage is occupied.
   `CFR_ASSERT_IMP(a_no_overrun, clock, reset, push_valid, !skid_valid_ff,
      "item pushed into a full buffer")
   // A drained skid item moves forward and frees the stage.
   `CFR_ASSERT_NEXT(a_skid_drain, clock, reset, skid_valid_ff && !rsp_stall,
      out_valid_ff && !skid_valid_ff, "skid item not moved forward")

endmodule

`default_nettype wire

// ===== hw/rtl/checksummed_frame_receiver.sv =====
// Checksummed frame receiver top level; uses cfr_pkg, cfr_parser and cfr_out_buf.
// A result is registered in the result buffer before the rsp_ channel shows it.
// Throughput: one byte per cycle; req_stall holds it off only while two results wait.
// Reset (synchronous, active high) returns the parser to hunting, empties the
// result buffer and sets frame_id to 0 and max_payload to 65535.
`timescale 1ns / 1ps
`default_nettype none

module checksummed_frame_receiver (
   input  wire logic        clock,
   input  wire logic        reset,
   // Received byte channel.
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,
   // Result channel.
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_kind,
   output logic [7:0]       rsp_data_byte,
   output logic [15:0]      rsp_frame_length,
   // Configuration write port.
   input  wire logic        csr_write,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata
);

   // The configuration registers live here. A write takes effect on the next
   // item: frame_id is only looked at while hunting, max_payload only when
   // the low length byte arrives.
   cfr_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            cfr_pkg::CSR_FRAME_ID:    cfg_in.frame_id    = csr_wdata[7:0];
            cfr_pkg::CSR_MAX_PAYLOAD: cfg_in.max_payload = csr_wdata;
            default:                  cfg_in             = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_id    <= cfr_pkg::FRAME_ID_RESET;
         cfg_ff.max_payload <= cfr_pkg::MAX_PAYLOAD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // An item is taken whenever the skid stage of the result buffer is free.
   // The stall is a plain register output, so it never depends on req_valid.
   logic               accept;
   logic               res_valid;
   cfr_pkg::item_type  res_item;
   cfr_pkg::item_type  out_item;
   logic               buf_full;

   assign req_stall = buf_full;
   assign accept    = req_valid && !buf_full;

   // The parser consumes one byte per accepted item in a single pass and
   // produces at most one result for it.
   cfr_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .rx_byte   (req_rx_byte),
      .cfg       (cfg_ff),
      .res_valid (res_valid),
      .res_item  (res_item)
   );

   // The result register and its skid stage decouple the two channels, so a
   // new byte is taken while a finished result still waits to be read.
   cfr_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push_valid (res_valid),
      .push_item  (res_item),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_item   (out_item),
      .full       (buf_full)
   );

   assign rsp_kind         = out_item.kind;
   assign rsp_data_byte    = out_item.data_byte;
   assign rsp_frame_length = out_item.frame_length;

endmodule

`default_nettype wire

// ===== dv/checksummed_frame_receiver_test.sv =====
// Self-checking testbench for the checksummed frame receiver: a directed opening and then
// randomised frame traffic, checked result by result against a predictor of the parser.
// Depends on cfr_pkg and checksummed_frame_receiver.
`timescale 1ns / 1ps

module checksummed_frame_receiver_test;

   // Run-length knobs. SETTLE_CYCLES lets the parser settle once the last result is in.
   localparam int SETTLE_CYCLES = 4;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int HOLD_CYCLES   = 300;
   localparam int PHASE_BYTES   = 255;
   localparam int MAX_REPORTS   = 10;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_kind;
   logic [7:0]  rsp_data_byte;
   logic [15:0] rsp_frame_length;
   logic        csr_write = 1'b0;
   logic        csr_index = cfr_pkg::CSR_FRAME_ID;
   logic [15:0] csr_wdata = 16'h0000;

   checksummed_frame_receiver uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_frame_length (rsp_frame_length),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #4 clock = ~clock;

   // Bytes waiting to be offered to the block, and the results that the bytes
   // already accepted are still owed.
   logic [7:0]        rx_stream[$];
   cfr_pkg::item_type awaited_results[$];

   // Our own copy of the registers, and of the parser's state.
   logic [7:0]         cfg_frame_id    = cfr_pkg::FRAME_ID_RESET;
   logic [15:0]        cfg_max_payload = cfr_pkg::MAX_PAYLOAD_RESET;
   cfr_pkg::phase_type rx_phase        = cfr_pkg::PH_HUNT;
   logic [15:0]        frame_len       = 16'h0000;
   logic [15:0]        frame_left      = 16'h0000;
   logic [7:0]         frame_sum       = 8'h00;

   // Handshake flags, set at the rising edge and read at the following falling edge.
   bit rx_taken  = 1'b0;
   bit rsp_taken = 1'b0;

   // Traffic shaping, switched per phase by the stimulus process.
   bit send_idling = 1'b1;
   bit recv_idling = 1'b1;
   int send_gap = 0;
   int recv_wait = 0;
   int recv_draw;
   int hold_requests = 0;
   int holds_served = 0;
   int hold_left = 0;

   int cycle_count = 0;
   int error_count = 0;
   int bytes_accepted = 0;
   int kind_counts[5] = '{default: 0};
   cfr_pkg::item_type oldest;

   // Advances the parser by one accepted byte and records the result it owes, if any.
   // Header bytes owe nothing unless oversize; every other byte owes exactly one result.
   function automatic void parse_byte(input logic [7:0] b);
      cfr_pkg::item_type owed;
      bit                owes;
      owes = 1'b0;
      owed.kind = cfr_pkg::K_DATA;
      owed.data_byte = 8'h00;
      owed.frame_length = 16'h0000;
      case (rx_phase)
         cfr_pkg::PH_LEN_HI: begin
            frame_len = {b, 8'h00};
            frame_sum = frame_sum + b;
            rx_phase = cfr_pkg::PH_LEN_LO;
         end
         cfr_pkg::PH_LEN_LO: begin
            frame_len[7:0] = b;
            frame_sum = frame_sum + b;
            // The limit is applied once the whole length is known.
            if (frame_len > cfg_max_payload) begin
               rx_phase = cfr_pkg::PH_HUNT;
               owed.kind = cfr_pkg::K_TOO_LONG;
               owed.frame_length = frame_len;
               owes = 1'b1;
            end else begin
               frame_left = frame_len;
               // An empty frame goes straight on to its checksum byte.
               rx_phase = (frame_len == 16'h0000) ? cfr_pkg::PH_CHECK : cfr_pkg::PH_PAYLOAD;
            end
         end
         cfr_pkg::PH_PAYLOAD: begin
            frame_sum = frame_sum + b;
            frame_left = frame_left - 16'h0001;
            if (frame_left == 16'h0000) rx_phase = cfr_pkg::PH_CHECK;
            owed.data_byte = b;
            owes = 1'b1;
         end
         cfr_pkg::PH_CHECK: begin
            rx_phase = cfr_pkg::PH_HUNT;
            owed.kind = (b == frame_sum) ? cfr_pkg::K_GOOD : cfr_pkg::K_BAD_SUM;
            owed.frame_length = frame_len;
            owes = 1'b1;
         end
         default: begin
            rx_phase = cfr_pkg::PH_HUNT;
            if (b == cfg_frame_id) begin
               frame_sum = b;
               frame_len = 16'h0000;
               frame_left = 16'h0000;
               rx_phase = cfr_pkg::PH_LEN_HI;
            end else begin
               owed.kind = cfr_pkg::K_BAD_ID;
               owes = 1'b1;
            end
         end
      endcase
      if (owes) awaited_results.push_back(owed);
   endfunction

   // Queues one frame and returns how many bytes it added. A length above the
   // current limit sends the header only. When cut is below the length, the frame
   // stops after cut payload bytes and has no checksum, leaving the parser to
   // swallow whatever follows as payload.
   function automatic int queue_frame(input logic [7:0] id, input int len, input bit corrupt,
                                      input int cut);
      logic [15:0] len_field;
      logic [7:0]  sum;
      logic [7:0]  pb;
      int          added;
      len_field = 16'(len);
      sum = id + len_field[15:8] + len_field[7:0];
      rx_stream.push_back(id);
      rx_stream.push_back(len_field[15:8]);
      rx_stream.push_back(len_field[7:0]);
      added = 3;
      if (len_field <= cfg_max_payload) begin
         for (int i = 0; i < len && i < cut; i++) begin
            pb = 8'($urandom_range(0, 255));
            sum = sum + pb;
            rx_stream.push_back(pb);
            added++;
         end
         if (cut >= len) begin
            rx_stream.push_back(corrupt ? sum + 8'($urandom_range(1, 255)) : sum);
            added++;
         end
      end
      return added;
   endfunction

   // Picks an acceptable payload length: mostly tiny, sometimes up to forty, and now
   // and then past 255 so that the upper length byte is exercised on good frames.
   function automatic int pick_length();
      int lim;
      int roll;
      lim = int'(cfg_max_payload);
      roll = $urandom_range(0, 99);
      if (roll < 2 && lim >= 256) return $urandom_range(256, (lim < 300) ? lim : 300);
      if (roll < 15) return $urandom_range(0, (lim < 40) ? lim : 40);
      return $urandom_range(0, (lim < 12) ? lim : 12);
   endfunction

   // Register writes happen only with nothing owed, and our copy follows once the
   // write has been clocked in.
   task automatic write_reg(input logic idx, input logic [15:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      if (idx == cfr_pkg::CSR_FRAME_ID) cfg_frame_id = value[7:0];
      else cfg_max_payload = value;
   endtask

   // Waits until every queued byte has been taken and every owed result has come
   // back, then lets a header byte that owes nothing work its way through.
   task automatic drain();
      while (rx_stream.size() != 0 || req_valid || awaited_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Sender. Each byte carries its own gap, drawn when it is launched and served
   // once it has been taken. A stalled byte is held exactly as it is.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else if (req_valid && !rx_taken) begin
         req_valid <= 1'b1;
      end else if (send_gap > 0) begin
         req_valid <= 1'b0;
         send_gap <= send_gap - 1;
      end else if (rx_stream.size() != 0) begin
         req_valid <= 1'b1;
         req_rx_byte <= rx_stream.pop_front();
         send_gap <= send_idling ? $urandom_range(0, 12) : 0;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Receiver. After each result it takes it draws a stall of its own. A hold-off
   // request from the stimulus keeps it stalled for a long stretch, which it counts
   // itself, so that the block's buffer fills and the input side backs up.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_wait <= 0;
         hold_left <= 0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (holds_served != hold_requests) begin
         rsp_stall <= 1'b1;
         holds_served <= hold_requests;
         hold_left <= HOLD_CYCLES;
      end else begin
         recv_draw = rsp_taken ? (recv_idling ? $urandom_range(0, 12) : 0) : recv_wait;
         rsp_stall <= (recv_draw > 0);
         recv_wait <= (recv_draw > 0) ? recv_draw - 1 : 0;
      end
   end

   // Monitor. The result is checked before the byte of the same edge is parsed, so
   // that a stray result can never be matched against the byte that arrives with it.
   always @(posedge clock) begin
      cycle_count++;
      rx_taken = 1'b0;
      rsp_taken = 1'b0;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            rsp_taken = 1'b1;
            if (rsp_kind <= cfr_pkg::K_BAD_SUM) kind_counts[rsp_kind]++;
            if (awaited_results.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("%0t: unexpected result kind %0d data %02h length %0d", $realtime,
                           rsp_kind, rsp_data_byte, rsp_frame_length);
            end else begin
               oldest = awaited_results.pop_front();
               if (rsp_kind !== oldest.kind || rsp_data_byte !== oldest.data_byte ||
                   rsp_frame_length !== oldest.frame_length) begin
                  error_count++;
                  if (error_count <= MAX_REPORTS)
                     $display("%0t: expected kind %0d data %02h length %0d, got %0d %02h %0d",
                              $realtime, oldest.kind, oldest.data_byte, oldest.frame_length,
                              rsp_kind, rsp_data_byte, rsp_frame_length);
               end
            end
         end
         if (req_valid && !req_stall) begin
            rx_taken = 1'b1;
            bytes_accepted++;
            parse_byte(req_rx_byte);
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("Timed out after %0d cycles with %0d results owed", cycle_count,
               awaited_results.size());
      $display("Test completed with failures");
      $finish;
   end

   // Stimulus: a directed opening, then six random phases, each with its own
   // register settings and traffic shape.
   initial begin
      int queued;
      int roll;
      int len;
      logic [7:0] noise;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: an empty frame, a stray byte, and a single-byte frame with a
      // broken checksum.
      void'(queue_frame(8'h00, 0, 1'b0, 1));
      rx_stream.push_back(8'hFF);
      void'(queue_frame(8'h00, 1, 1'b1, 1));
      drain();
      // A length of all ones, one above the limit.
      write_reg(cfr_pkg::CSR_MAX_PAYLOAD, 16'hFFFE);
      void'(queue_frame(8'h00, 65535, 1'b0, 0));
      drain();
      // With no payload allowed only empty frames get through.
      write_reg(cfr_pkg::CSR_FRAME_ID, 16'h00FF);
      write_reg(cfr_pkg::CSR_MAX_PAYLOAD, 16'h0000);
      void'(queue_frame(8'hFF, 0, 1'b0, 1));
      void'(queue_frame(8'hFF, 1, 1'b0, 1));
      rx_stream.push_back(8'h00);
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin
               write_reg(cfr_pkg::CSR_FRAME_ID, 16'($urandom_range(1, 254)));
               write_reg(cfr_pkg::CSR_MAX_PAYLOAD, 16'hFFFF);
               send_idling = 1'b1;
               recv_idling = 1'b1;
            end
            1: begin
               write_reg(cfr_pkg::CSR_FRAME_ID, 16'h00FF);
               write_reg(cfr_pkg::CSR_MAX_PAYLOAD, 16'h0000);
               send_idling = 1'b0;
               recv_idling = 1'b0;
            end
            2: begin
               write_reg(cfr_pkg::CSR_FRAME_ID, 16'h0000);
               write_reg(cfr_pkg::CSR_MAX_PAYLOAD, 16'($urandom_range(1, 20)));
               send_idling = 1'b1;
               recv_idling = 1'b1;
            end
            3: begin
               write_reg(cfr_pkg::CSR_FRAME_ID, 16'($urandom_range(0, 255)));
               write_reg(cfr_pkg::CSR_MAX_PAYLOAD, 16'hFFFF);
               send_idling = 1'b0;
               recv_idling = 1'b1;
            end
            4: begin
               write_reg(cfr_pkg::CSR_FRAME_ID, 16'($urandom_range(0, 255)));
               write_reg(cfr_pkg::CSR_MAX_PAYLOAD, 16'($urandom_range(100, 300)));
               send_idling = 1'b1;
               recv_idling = 1'b0;
            end
            default: begin
               write_reg(cfr_pkg::CSR_FRAME_ID, 16'($urandom_range(0, 255)));
               write_reg(cfr_pkg::CSR_MAX_PAYLOAD, 16'($urandom_range(1, 65534)));
               send_idling = 1'b1;
               recv_idling = 1'b1;
            end
         endcase

         // Mostly well-formed frames with random content; the rest are oversize
         // lengths, stray bytes and frames cut short.
         queued = 0;
         while (queued < PHASE_BYTES) begin
            roll = $urandom_range(0, 99);
            if (roll < 70 || (roll < 80 && cfg_max_payload == 16'hFFFF)) begin
               len = pick_length();
               queued += queue_frame(cfg_frame_id, len, $urandom_range(0, 99) < 15, len);
            end else if (roll < 80) begin
               len = $urandom_range(int'(cfg_max_payload) + 1, 65535);
               queued += queue_frame(cfg_frame_id, len, 1'b0, 0);
            end else if (roll < 92 || cfg_max_payload > 16'd255 || cfg_max_payload == 16'd0)
            begin
               // A stray byte that cannot be taken for the start of a frame.
               noise = 8'($urandom_range(0, 255));
               if (noise == cfg_frame_id) noise = ~noise;
               rx_stream.push_back(noise);
               queued++;
            end else begin
               // Cut short only where the limit is low, so that a false frame start in
               // the bytes that follow cannot demand a huge payload.
               len = $urandom_range(1, cfg_max_payload);
               queued += queue_frame(cfg_frame_id, len, 1'b0, $urandom_range(0, len - 1));
            end
         end
         // The sender runs flat out here while the receiver holds off.
         if (ph == 3) hold_requests++;
         drain();
      end

      $display("Accepted %0d bytes: %0d payload bytes, %0d good and %0d bad-checksum frames,",
               bytes_accepted, kind_counts[cfr_pkg::K_DATA], kind_counts[cfr_pkg::K_GOOD],
               kind_counts[cfr_pkg::K_BAD_SUM]);
      $display("%0d id mismatches and %0d oversize lengths over six register settings",
               kind_counts[cfr_pkg::K_BAD_ID], kind_counts[cfr_pkg::K_TOO_LONG]);
      if (error_count == 0 && awaited_results.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
